@@ hw/rtl/gac_pkg.sv @@
// Package for the complex Gabor analysis block: word types, codes and sizes,
// the cosine polynomial and the Q15 rounding helper.
// Used by every module of the block but the RAM, and by its checker.
package gac_pkg;

  localparam int MAX_SIGNAL   = 4096;
  localparam int MAX_WINDOW   = 1024;
  localparam int MAX_CHANNELS = 64;
  localparam int SAMPLE_WIDTH = 16;

  localparam int SIG_AW  = $clog2(MAX_SIGNAL);
  localparam int WIN_AW  = $clog2(MAX_WINDOW);
  localparam int CH_AW   = $clog2(MAX_CHANNELS);
  localparam int FOLD_W  = 28;
  localparam int ACC_W   = 36;
  localparam int OUT_W   = 40;

  localparam int DIV_NUM_W = 37;
  localparam int DIV_DEN_W = 13;
  localparam int DIV_REM_W = 12;
  localparam int DIV_CNT_W = 6;

  // Operation codes of an input word.
  localparam logic [1:0] OP_WIN   = 2'd0;
  localparam logic [1:0] OP_SIG   = 2'd1;
  localparam logic [1:0] OP_FRAME = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HOP      = 2'd0;
  localparam logic [1:0] CFG_CHANNELS = 2'd1;
  localparam logic [1:0] CFG_WIN_LEN  = 2'd2;
  localparam logic [1:0] CFG_SIG_LEN  = 2'd3;

  localparam logic [2:0] COS_TOP = 3'd5;

  typedef struct packed {
    logic [1:0]                     operation;
    logic [11:0]                    index;
    logic signed [SAMPLE_WIDTH-1:0] value_re;
    logic signed [SAMPLE_WIDTH-1:0] value_im;
  } item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] coef_re;
    logic signed [OUT_W-1:0] coef_im;
    logic [5:0]              bin;
    logic                    last;
  } coef_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_REM_W-1:0] rem;
  } div_rsp_t;

  // Q30 coefficients of the quarter-wave cosine polynomial in w = z*z.
  function automatic logic signed [31:0] cos_coef(input logic [2:0] i);
    logic signed [31:0] c;
    case (i)
      3'd0: c = 32'sd1073741824;
      3'd1: c = -32'sd1324675879;
      3'd2: c = 32'sd272375560;
      3'd3: c = -32'sd22401992;
      3'd4: c = 32'sd987048;
      3'd5: c = -32'sd27061;
      default: c = 32'sd0;
    endcase
    return c;
  endfunction

  // Q30 to Q15, rounded half away from zero and limited to +-32767.
  function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
    logic [32:0] mag;
    logic [32:0] r;
    mag = v[32] ? 33'(-v) : v;
    r = (mag + 33'd16384) >> 15;
    if (r > 33'd32767) begin
      r = 33'd32767;
    end
    return v[32] ? -16'(r) : 16'(r);
  endfunction

endpackage

@@ hw/rtl/gac_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module gac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/gac_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by the frame sequencer.
// Depends on gac_pkg for the request and response words.
module gac_div import gac_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] quot;
  logic [DIV_REM_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W-1:0] trial;
  logic                 ge;

  // Shift the next dividend bit into the partial remainder and compare.
  assign trial = {rem, quot[DIV_NUM_W-1]};
  assign ge    = trial >= den;

  // Control: busy flag, bit counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Data path: quotient shifts in from the right as the dividend leaves.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.num;
      rem  <= '0;
      den  <= req.den;
    end else if (busy) begin
      quot <= {quot[DIV_NUM_W-2:0], ge};
      rem  <= ge ? DIV_REM_W'(trial - den) : trial[DIV_REM_W-1:0];
    end
  end

  assign rsp = '{done: done, quot: quot, rem: rem};

endmodule

@@ hw/rtl/gabor_analysis_complex.sv @@
// Gabor analysis of one complex channel. Loads are taken while the block is idle. The time
// a frame takes is set by the single 32x18 multiplier that serves four products per tap
// and per DFT term, plus two divides. The first frame after reset or after a channels write
// first rebuilds the twiddle table. Reset is synchronous and clears control state only;
// the sample, window, fold and twiddle memories keep their contents.
module gabor_analysis_complex import gac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        coef_valid,
  input  logic        coef_ready,
  output coef_t       coef,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_BASE  = 18'h00002,
    ST_BASE2 = 18'h00004,
    ST_MODL  = 18'h00008,
    ST_MODM  = 18'h00010,
    ST_TWQ   = 18'h00020,
    ST_TWQW  = 18'h00040,
    ST_QCDIV = 18'h00080,
    ST_SQ    = 18'h00100,
    ST_HRN   = 18'h00200,
    ST_TWWR  = 18'h00400,
    ST_FSET  = 18'h00800,
    ST_FRD   = 18'h01000,
    ST_FMUL  = 18'h02000,
    ST_DSET  = 18'h04000,
    ST_DRD   = 18'h08000,
    ST_DMUL  = 18'h10000,
    ST_DOUT  = 18'h20000
  } state_t;

  state_t state;

  logic [12:0] hop;
  logic [6:0]  channels;
  logic [10:0] window_len;
  logic [12:0] signal_len;
  logic        tw_ok;

  logic [6:0]  m;
  logic [12:0] len;
  logic [10:0] gl;
  logic [9:0]  h;

  logic [11:0] n;
  logic [25:0] bmag;
  logic        bneg;
  logic signed [26:0] base;

  logic [SIG_AW-1:0] sidx;
  logic [WIN_AW-1:0] gi;
  logic [CH_AW-1:0]  dst;
  logic [CH_AW-1:0]  rot;
  logic [CH_AW-1:0]  fc;
  logic [10:0]       l;
  logic              nofold;

  logic [CH_AW-1:0]  tj;
  logic [1:0]        tq;
  logic [CH_AW-1:0]  tr;
  logic              pass;
  logic [30:0]       z;
  logic [30:0]       w;
  logic signed [32:0] hacc;
  logic [2:0]        hi;
  logic signed [15:0] cp;
  logic signed [15:0] sp;

  logic [2:0]         ph;
  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [49:0] prod;
  logic signed [63:0] macc;
  logic signed [44:0] tre;
  logic signed [44:0] tim;
  logic signed [29:0] re_term;
  logic signed [29:0] im_term;

  logic [CH_AW-1:0]   k;
  logic [CH_AW-1:0]   jj;
  logic [CH_AW-1:0]   tix;
  logic [6:0]         tsum;
  logic signed [ACC_W-1:0] xr;
  logic signed [ACC_W-1:0] xi;

  logic [63:0]        wsum;
  logic [63:0]        rnd;
  logic [32:0]        hmag;
  logic [32:0]        pmag;
  logic signed [32:0] hterm;
  logic signed [32:0] hnext;

  logic [11:0]        r_sig;
  logic [CH_AW-1:0]   r_ch;

  div_req_t dreq;
  div_rsp_t drsp;
  logic     div_go;

  logic                 accept;
  logic                 win_we;
  logic                 sig_we;
  logic [31:0]          win_rdata;
  logic [31:0]          sig_rdata;
  logic                 fold_we;
  logic [CH_AW-1:0]     fold_raddr;
  logic [2*FOLD_W-1:0]  fold_wdata;
  logic [2*FOLD_W-1:0]  fold_rdata;
  logic                 tw_we;
  logic [31:0]          tw_wdata;
  logic [31:0]          tw_rdata;

  logic signed [15:0]       fr, fi, gr, gim, tc, ts;
  logic signed [FOLD_W-1:0] old_re, old_im, sr, si;
  logic                     first;

  // Effective frame geometry from the configuration registers.
  assign m   = (channels == 7'd0) ? 7'd1 :
               (channels > 7'(MAX_CHANNELS)) ? 7'(MAX_CHANNELS) : channels;
  assign len = (signal_len == 13'd0) ? 13'd1 :
               (signal_len > 13'(MAX_SIGNAL)) ? 13'(MAX_SIGNAL) : signal_len;
  assign gl  = (window_len > 11'(MAX_WINDOW)) ? 11'(MAX_WINDOW) : window_len;
  assign h   = gl[10:1];

  assign accept     = item_valid && item_ready;
  assign item_ready = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;

  // Sample and tap stores, written straight from the input word.
  assign win_we = accept && (item.operation == OP_WIN) && (item.index < 12'(MAX_WINDOW));
  assign sig_we = accept && (item.operation == OP_SIG);

  gac_ram #(.WIDTH(32), .DEPTH(MAX_WINDOW)) u_win (
    .clk(clk), .we(win_we), .waddr(item.index[WIN_AW-1:0]),
    .wdata({item.value_re, item.value_im}), .raddr(gi), .rdata(win_rdata)
  );

  gac_ram #(.WIDTH(32), .DEPTH(MAX_SIGNAL)) u_sig (
    .clk(clk), .we(sig_we), .waddr(item.index[SIG_AW-1:0]),
    .wdata({item.value_re, item.value_im}), .raddr(sidx), .rdata(sig_rdata)
  );

  // Fold buffer: read-modify-write per tap, then read per DFT term.
  assign fold_raddr = (state == ST_FRD || state == ST_FMUL) ? dst : jj;
  assign fold_we    = (state == ST_FMUL) && (ph == 3'd4);
  assign first      = (l < 11'(m));
  assign old_re     = first ? '0 : fold_rdata[2*FOLD_W-1:FOLD_W];
  assign old_im     = first ? '0 : fold_rdata[FOLD_W-1:0];
  assign fold_wdata = {FOLD_W'(old_re + FOLD_W'(re_term)), FOLD_W'(old_im + FOLD_W'(im_term))};

  gac_ram #(.WIDTH(2*FOLD_W), .DEPTH(MAX_CHANNELS)) u_fold (
    .clk(clk), .we(fold_we), .waddr(dst), .wdata(fold_wdata),
    .raddr(fold_raddr), .rdata(fold_rdata)
  );

  // Twiddle table, rebuilt from the quarter-wave values after a channels change.
  assign tw_we = (state == ST_TWWR);
  always_comb begin
    case (tq)
      2'd0:    tw_wdata = {cp, sp};
      2'd1:    tw_wdata = {-sp, cp};
      2'd2:    tw_wdata = {-cp, -sp};
      default: tw_wdata = {sp, -cp};
    endcase
  end

  gac_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_tw (
    .clk(clk), .we(tw_we), .waddr(tj), .wdata(tw_wdata),
    .raddr(tix), .rdata(tw_rdata)
  );

  gac_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Divider start for the offset reductions and the twiddle angles.
  always_comb begin
    case (state)
      ST_BASE2: div_go = 1'b1;
      ST_MODL:  div_go = drsp.done;
      ST_TWQ:   div_go = 1'b1;
      ST_TWQW:  div_go = drsp.done;
      ST_HRN:   div_go = (ph == 3'd2) && (hi == 3'd0) && !pass;
      default:  div_go = 1'b0;
    endcase
  end

  // Operand views of the memory read data.
  assign fr  = sig_rdata[31:16];
  assign fi  = sig_rdata[15:0];
  assign gr  = win_rdata[31:16];
  assign gim = win_rdata[15:0];
  assign tc  = tw_rdata[31:16];
  assign ts  = tw_rdata[15:0];
  assign sr  = nofold ? '0 : fold_rdata[2*FOLD_W-1:FOLD_W];
  assign si  = nofold ? '0 : fold_rdata[FOLD_W-1:0];

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_BASE: begin
        mul_a = 32'(n);
        mul_b = 18'(hop);
      end
      ST_SQ: begin
        mul_a = 32'(z);
        mul_b = (ph == 3'd0) ? 18'(z[15:0]) : 18'(z[30:16]);
      end
      ST_HRN: begin
        mul_a = 32'(hmag[30:0]);
        mul_b = (ph == 3'd0) ? 18'(w[15:0]) : 18'(w[30:16]);
      end
      ST_FMUL: begin
        mul_a = (ph == 3'd0 || ph == 3'd3) ? 32'(fr) : 32'(fi);
        mul_b = (ph == 3'd0 || ph == 3'd2) ? 18'(gr) : 18'(gim);
      end
      ST_DMUL: begin
        mul_a = (ph == 3'd0 || ph == 3'd3) ? 32'(sr) : 32'(si);
        mul_b = (ph == 3'd0 || ph == 3'd2) ? 18'(tc) : 18'(ts);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Two-half products for the Q30 polynomial, rounded to Q30.
  assign wsum  = macc + {prod[47:0], 16'd0};
  assign rnd   = wsum + 64'h2000_0000;
  assign hmag  = hacc[32] ? 33'(-hacc) : hacc;
  assign pmag  = rnd[62:30];
  assign hterm = hacc[32] ? 33'(-$signed(pmag)) : $signed(pmag);
  assign hnext = 33'(cos_coef(hi)) + hterm;

  // Complex product terms, floored by 15 bits.
  assign tim     = 45'(macc - prod);
  assign re_term = tre[44:15];
  assign im_term = tim[44:15];

  // Frame start offset and its wrapped forms.
  assign base  = $signed({2'b00, prod[24:0]}) - $signed({17'd0, h});
  assign r_sig = drsp.rem;
  assign r_ch  = drsp.rem[CH_AW-1:0];
  assign tsum  = 7'(tix) + 7'(k);

  // Sequencer, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hop        <= 13'd1;
      channels   <= 7'd64;
      window_len <= 11'd64;
      signal_len <= 13'd4096;
      tw_ok      <= 1'b0;
      coef_valid <= 1'b0;
      dreq.start <= 1'b0;
      ph         <= '0;
    end else begin
      dreq.start <= div_go;
      // A taken word frees the output register unless the next one moves in.
      if (coef_valid && coef_ready && state != ST_DOUT) begin
        coef_valid <= 1'b0;
      end

      // Register writes must come only while the block is idle; the block does not enforce this.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HOP:      hop <= cfg_data;
          CFG_CHANNELS: begin
            channels <= cfg_data[6:0];
            tw_ok    <= 1'b0;
          end
          CFG_WIN_LEN:  window_len <= cfg_data[10:0];
          CFG_SIG_LEN:  signal_len <= cfg_data;
          default:      hop <= hop;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (accept && item.operation == OP_FRAME) begin
            n     <= item.index;
            state <= ST_BASE;
          end
        end
        ST_BASE: begin
          state <= ST_BASE2;
        end
        // Split the signed offset into sign and magnitude, reduce modulo the length.
        ST_BASE2: begin
          bneg       <= base[26];
          bmag       <= base[26] ? 26'(-base) : 26'(base);
          dreq.num   <= DIV_NUM_W'(base[26] ? 26'(-base) : 26'(base));
          dreq.den   <= len;
          state      <= ST_MODL;
        end
        ST_MODL: begin
          if (drsp.done) begin
            sidx       <= (bneg && r_sig != '0) ? SIG_AW'(len - 13'(r_sig)) : r_sig;
            dreq.num   <= DIV_NUM_W'(bmag);
            dreq.den   <= DIV_DEN_W'(m);
            state      <= ST_MODM;
          end
        end
        ST_MODM: begin
          if (drsp.done) begin
            rot   <= (bneg && r_ch != '0) ? CH_AW'(m - 7'(r_ch)) : r_ch;
            tj    <= '0;
            state <= tw_ok ? ST_FSET : ST_TWQ;
          end
        end
        // Twiddle j: quadrant and remainder of 4j over M.
        ST_TWQ: begin
          dreq.num   <= DIV_NUM_W'({tj, 2'b00});
          dreq.den   <= DIV_DEN_W'(m);
          state      <= ST_TWQW;
        end
        ST_TWQW: begin
          if (drsp.done) begin
            tq         <= drsp.quot[1:0];
            tr         <= r_ch;
            pass       <= 1'b0;
            dreq.num   <= {7'(r_ch), 30'd0};
            dreq.den   <= DIV_DEN_W'(m);
            state      <= ST_QCDIV;
          end
        end
        ST_QCDIV: begin
          if (drsp.done) begin
            z     <= drsp.quot[30:0];
            ph    <= '0;
            state <= ST_SQ;
          end
        end
        // w = z*z in Q30 from two half products.
        ST_SQ: begin
          if (ph == 3'd0) begin
            ph <= 3'd1;
          end else if (ph == 3'd1) begin
            macc <= 64'(prod);
            ph   <= 3'd2;
          end else begin
            w     <= rnd[60:30];
            hacc  <= 33'(cos_coef(COS_TOP));
            hi    <= COS_TOP - 3'd1;
            ph    <= '0;
            state <= ST_HRN;
          end
        end
        // Horner step of the cosine polynomial.
        ST_HRN: begin
          if (ph == 3'd0) begin
            ph <= 3'd1;
          end else if (ph == 3'd1) begin
            macc <= 64'(prod);
            ph   <= 3'd2;
          end else begin
            hacc <= hnext;
            ph   <= '0;
            if (hi == 3'd0) begin
              if (!pass) begin
                cp         <= to_q15(hnext);
                pass       <= 1'b1;
                dreq.num   <= {7'(m - 7'(tr)), 30'd0};
                dreq.den   <= DIV_DEN_W'(m);
                state      <= ST_QCDIV;
              end else begin
                sp    <= to_q15(hnext);
                state <= ST_TWWR;
              end
            end else begin
              hi <= hi - 3'd1;
            end
          end
        end
        ST_TWWR: begin
          if (7'(tj) == m - 7'd1) begin
            tw_ok <= 1'b1;
            state <= ST_FSET;
          end else begin
            tj    <= tj + 1'b1;
            state <= ST_TWQ;
          end
        end
        // Window walk: start at the centered tap, folds of M taps.
        ST_FSET: begin
          l     <= '0;
          fc    <= '0;
          dst   <= rot;
          gi    <= (h == '0) ? '0 : WIN_AW'(gl - 11'(h));
          state <= ST_FRD;
        end
        ST_FRD: begin
          if (fc == '0 && (12'(l) + 12'(m) > 12'(gl))) begin
            nofold <= (l == '0);
            state  <= ST_DSET;
          end else begin
            ph    <= '0;
            state <= ST_FMUL;
          end
        end
        ST_FMUL: begin
          case (ph)
            3'd0: ph <= 3'd1;
            3'd1: begin
              macc <= 64'(prod);
              ph   <= 3'd2;
            end
            3'd2: begin
              tre <= 45'(macc + prod);
              ph  <= 3'd3;
            end
            3'd3: begin
              macc <= 64'(prod);
              ph   <= 3'd4;
            end
            default: begin
              l     <= l + 11'd1;
              fc    <= (7'(fc) + 7'd1 == m) ? '0 : fc + 1'b1;
              dst   <= (7'(dst) + 7'd1 == m) ? '0 : dst + 1'b1;
              gi    <= (11'(gi) + 11'd1 == gl) ? '0 : gi + 1'b1;
              sidx  <= (13'(sidx) + 13'd1 == len) ? '0 : sidx + 1'b1;
              state <= ST_FRD;
            end
          endcase
        end
        // DFT over the fold buffer, one term per visit.
        ST_DSET: begin
          k     <= '0;
          jj    <= '0;
          tix   <= '0;
          xr    <= '0;
          xi    <= '0;
          state <= ST_DRD;
        end
        ST_DRD: begin
          ph    <= '0;
          state <= ST_DMUL;
        end
        ST_DMUL: begin
          case (ph)
            3'd0: ph <= 3'd1;
            3'd1: begin
              macc <= 64'(prod);
              ph   <= 3'd2;
            end
            3'd2: begin
              tre <= 45'(macc + prod);
              ph  <= 3'd3;
            end
            3'd3: begin
              macc <= 64'(prod);
              ph   <= 3'd4;
            end
            default: begin
              xr <= xr + ACC_W'(re_term);
              xi <= xi + ACC_W'(im_term);
              if (7'(jj) == m - 7'd1) begin
                state <= ST_DOUT;
              end else begin
                jj    <= jj + 1'b1;
                tix   <= (tsum >= m) ? CH_AW'(tsum - m) : CH_AW'(tsum);
                state <= ST_DRD;
              end
            end
          endcase
        end
        // Hand the coefficient to the output register once it is free.
        ST_DOUT: begin
          if (!coef_valid || coef_ready) begin
            coef_valid   <= 1'b1;
            coef.coef_re <= OUT_W'(xr);
            coef.coef_im <= OUT_W'(xi);
            coef.bin     <= k;
            coef.last    <= (7'(k) == m - 7'd1);
            if (7'(k) == m - 7'd1) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              jj    <= '0;
              tix   <= '0;
              xr    <= '0;
              xi    <= '0;
              state <= ST_DRD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/gac_checker.sv @@
// Port-level checker for the Gabor analysis block, bound to the top level.
// Depends on gac_pkg for the operation codes and word types.
module gac_checker import gac_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  item_valid,
  input logic  item_ready,
  input item_t item,
  input logic  coef_valid,
  input logic  coef_ready,
  input coef_t coef
);

  // A stalled coefficient word holds.
  a_coef_hold: assert property (@(posedge clk) disable iff (rst)
    coef_valid && !coef_ready |=> coef_valid && $stable(coef))
    else $error("coefficient word changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !coef_valid)
    else $error("coefficient valid after reset");

  // A frame request makes the block busy on the next cycle.
  a_frame_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.operation == OP_FRAME |=> !item_ready)
    else $error("block ready right after a frame request");

  // Loads never produce a coefficient.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.operation != OP_FRAME && !coef_valid
    |=> !coef_valid)
    else $error("coefficient appeared after a load");

endmodule

bind gabor_analysis_complex gac_checker u_gac_checker (
  .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready), .item(item),
  .coef_valid(coef_valid), .coef_ready(coef_ready), .coef(coef)
);

@@ test/gabor_analysis_complex_test.sv @@
// Testbench for the complex Gabor analysis block: a bit-exact frame predictor in a
// small scoreboard class, random stimulus over several register settings, random stalls.
// Depends on gac_pkg and the gabor_analysis_complex RTL only.
`timescale 1ns / 1ps

module gabor_analysis_complex_test;
  import gac_pkg::*;

  // Predicts the coefficient words of each frame request and checks the block's output.
  class coef_scoreboard;
    int unsigned hop, channels, window_len, signal_len;
    int sig_re[MAX_SIGNAL], sig_im[MAX_SIGNAL];
    int win_re[MAX_WINDOW], win_im[MAX_WINDOW];
    int tw_cos[MAX_CHANNELS], tw_sin[MAX_CHANNELS];
    coef_t expected_coefs[$];
    int errors;

    function new();
      hop = 1; channels = 64; window_len = 64; signal_len = 4096;
      errors = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
    endtask

    function void configure(logic [1:0] idx, logic [12:0] data);
      case (idx)
        CFG_HOP:      hop = data;
        CFG_CHANNELS: channels = data[6:0];
        CFG_WIN_LEN:  window_len = data[10:0];
        CFG_SIG_LEN:  signal_len = data;
        default: ;
      endcase
    endfunction

    function longint sat(longint x, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return x > hi ? hi : (x < lo ? lo : x);
    endfunction

    function longint posmod(longint x, longint m);
      longint r;
      r = x % m;
      return r < 0 ? r + m : r;
    endfunction

    function longint mul_q30(longint a, longint unsigned w);
      longint unsigned mag, p;
      mag = a < 0 ? -a : a;
      p = (mag * w + (64'd1 << 29)) >> 30;
      return a < 0 ? -longint'(p) : longint'(p);
    endfunction

    function longint quarter_cos(int unsigned s, int unsigned m);
      longint poly[6];
      longint unsigned z, w;
      longint acc;
      poly = '{1073741824, -1324675879, 272375560, -22401992, 987048, -27061};
      z = (longint'(s) << 30) / m;
      w = (z * z + (64'd1 << 29)) >> 30;
      acc = poly[5];
      for (int i = 4; i >= 0; i--) acc = poly[i] + mul_q30(acc, w);
      return acc;
    endfunction

    function int q15(longint v);
      longint unsigned mag, r;
      mag = v < 0 ? -v : v;
      r = (mag + (64'd1 << 14)) >> 15;
      if (r > 32767) r = 32767;
      return v < 0 ? -int'(r) : int'(r);
    endfunction

    function void build_twiddles(int unsigned m);
      int unsigned q, r;
      int cp, sp;
      for (int unsigned j = 0; j < m; j++) begin
        q = (4 * j) / m;
        r = 4 * j - q * m;
        cp = q15(quarter_cos(r, m));
        sp = q15(quarter_cos(m - r, m));
        case (q)
          0: begin tw_cos[j] = cp;  tw_sin[j] = sp;  end
          1: begin tw_cos[j] = -sp; tw_sin[j] = cp;  end
          2: begin tw_cos[j] = -cp; tw_sin[j] = -sp; end
          default: begin tw_cos[j] = sp; tw_sin[j] = -cp; end
        endcase
      end
    endfunction

    // Window product, fold into M channels, then an M-point forward DFT.
    function void predict_frame(int unsigned n);
      int unsigned m, len, gl, h, used, sidx, rot, gi, dst, t;
      longint base, fr, fi, gr, gm, xr, xi, c, s;
      longint fold_re[MAX_CHANNELS], fold_im[MAX_CHANNELS];
      coef_t w;
      m = channels == 0 ? 1 : (channels > MAX_CHANNELS ? MAX_CHANNELS : channels);
      len = signal_len == 0 ? 1 : (signal_len > MAX_SIGNAL ? MAX_SIGNAL : signal_len);
      gl = window_len > MAX_WINDOW ? MAX_WINDOW : window_len;
      h = gl / 2;
      used = (gl / m) * m;
      base = longint'(n) * longint'(hop) - longint'(h);
      sidx = posmod(base, len);
      rot = posmod(base, m);
      for (int j = 0; j < MAX_CHANNELS; j++) begin fold_re[j] = 0; fold_im[j] = 0; end
      for (int unsigned l = 0; l < used; l++) begin
        gi = l + (gl - h);
        if (gi >= gl) gi -= gl;
        fr = sig_re[sidx]; fi = sig_im[sidx];
        gr = win_re[gi];   gm = win_im[gi];
        dst = (l % m) + rot;
        if (dst >= m) dst -= m;
        fold_re[dst] += (fr * gr + fi * gm) >>> 15;
        fold_im[dst] += (fi * gr - fr * gm) >>> 15;
        sidx++;
        if (sidx >= len) sidx = 0;
      end
      for (int j = 0; j < MAX_CHANNELS; j++) begin
        fold_re[j] = sat(fold_re[j], 46);
        fold_im[j] = sat(fold_im[j], 46);
      end
      build_twiddles(m);
      for (int unsigned k = 0; k < m; k++) begin
        xr = 0; xi = 0;
        for (int unsigned j = 0; j < m; j++) begin
          t = (j * k) % m;
          c = tw_cos[t]; s = tw_sin[t];
          xr += (fold_re[j] * c + fold_im[j] * s) >>> 15;
          xi += (fold_im[j] * c - fold_re[j] * s) >>> 15;
        end
        xr = sat(xr, OUT_W);
        xi = sat(xi, OUT_W);
        w.coef_re = xr[OUT_W-1:0];
        w.coef_im = xi[OUT_W-1:0];
        w.bin = k[5:0];
        w.last = (k == m - 1);
        expected_coefs.push_back(w);
      end
    endfunction

    function void note_item(item_t it);
      case (it.operation)
        OP_WIN: if (it.index < MAX_WINDOW) begin
          win_re[it.index] = it.value_re; win_im[it.index] = it.value_im;
        end
        OP_SIG: begin
          sig_re[it.index] = it.value_re; sig_im[it.index] = it.value_im;
        end
        OP_FRAME: predict_frame(it.index);
        default: ;
      endcase
    endfunction

    task check_coef(coef_t got);
      coef_t want;
      if (expected_coefs.size() == 0) begin
        report("unexpected word, bin", got.bin, -1);
      end else begin
        want = expected_coefs.pop_front();
        if (got.coef_re !== want.coef_re) report("coef_re", got.coef_re, want.coef_re);
        if (got.coef_im !== want.coef_im) report("coef_im", got.coef_im, want.coef_im);
        if (got.bin !== want.bin) report("bin", got.bin, want.bin);
        if (got.last !== want.last) report("last", got.last, want.last);
      end
    endtask
  endclass

  localparam int WATCHDOG_LIMIT = 400000;
  // Low store entries loaded before any frame; window lengths stay within them.
  localparam int FILL = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic coef_valid;
  logic coef_ready = 1'b0;
  coef_t coef;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;

  coef_scoreboard sb = new();
  bit no_idle = 1'b0;
  int ready_hold = 0;
  int quiet_cycles = 0;

  gabor_analysis_complex DUT (.*);

  always #6 clk = ~clk;

  // Scoreboard taps, receiver stalls and the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) sb.note_item(item);
      if (coef_valid && coef_ready) sb.check_coef(coef);
      if ((item_valid && item_ready) || (coef_valid && coef_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (coef_valid && coef_ready) begin
        ready_hold = no_idle ? 0 : $urandom_range(0, 3);
        coef_ready <= (ready_hold == 0);
      end else if (ready_hold > 0) begin
        ready_hold--;
        coef_ready <= (ready_hold == 0);
      end else begin
        coef_ready <= 1'b1;
      end
    end
  end

  // Sends one input word, after a random gap of idle cycles unless no_idle is set.
  task send_item(logic [1:0] op, logic [11:0] idx, logic [15:0] vre, logic [15:0] vim);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{operation: op, index: idx, value_re: vre, value_im: vim};
    do @(posedge clk); while (!(item_valid && item_ready));
  endtask

  // Waits until every expected word has come, then lets the block settle.
  task drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_coefs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // One register write; the caller drops valid after its last write.
  task write_reg(logic [1:0] idx, logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.configure(idx, data);
  endtask

  task set_regs(int h, int m, int gl, int len);
    drain();
    write_reg(CFG_HOP, h);
    write_reg(CFG_CHANNELS, m);
    write_reg(CFG_WIN_LEN, gl);
    write_reg(CFG_SIG_LEN, len);
    cfg_valid <= 1'b0;
  endtask

  // Random words: mostly loads and frames, a little noise. Loads aim near the filled
  // entries so that frames see fresh values.
  task random_phase(int count, int frame_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < frame_pct)
        send_item(OP_FRAME, $urandom_range(0, 4095), $urandom, $urandom);
      else if (r < 95)
        send_item(r[0] ? OP_SIG : OP_WIN, $urandom_range(0, 2 * FILL - 1), $urandom, $urandom);
      else
        send_item(2'd3, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // Geometry that stays inside the filled entries.
    set_regs(1, 8, FILL, FILL);

    // Fill the low entries of both stores before any frame is requested.
    no_idle = 1'b1;
    for (int i = 0; i < FILL; i++) send_item(OP_WIN, i, $urandom, $urandom);
    for (int i = 0; i < FILL; i++) send_item(OP_SIG, i, $urandom, $urandom);
    no_idle = 1'b0;

    // Directed words: extreme values and indexes, ignored loads, edge frame numbers.
    send_item(OP_WIN, 0, 16'h8000, 16'h8000);
    send_item(OP_WIN, FILL - 1, 16'h7fff, 16'h7fff);
    send_item(OP_SIG, 0, 16'h7fff, 16'h8000);
    send_item(OP_SIG, FILL - 1, 16'h8000, 16'h7fff);
    send_item(OP_WIN, 1024, 16'h1234, 16'h4321);
    send_item(OP_WIN, 4095, 16'h7fff, 16'h8000);
    send_item(2'd3, 12'hfff, 16'hffff, 16'hffff);
    send_item(OP_FRAME, 0, 0, 0);
    send_item(OP_FRAME, 4095, 0, 0);
    // The sender holds off here until the frames above are fully out.
    drain();
    send_item(OP_FRAME, 12'h555, 0, 0);
    send_item(OP_FRAME, 12'haaa, 0, 0);

    // Smallest sizes and a hop of 4096.
    set_regs(4096, 1, 1, 1);
    random_phase(10, 50);
    // Zero hop and zero channels and signal length.
    set_regs(0, 0, 5, 0);
    random_phase(7, 50);
    // Window shorter than the channel count.
    set_regs(3, 3, 2, 9);
    random_phase(6, 50);
    // Moderate sizes, no idling on either side.
    no_idle = 1'b1;
    set_regs(13, 8, 21, 20);
    random_phase(8, 50);
    no_idle = 1'b0;
    set_regs(7, 5, FILL, 17);
    random_phase(7, 40);
    // Register values above the limits; the window is shorter than the clamped count.
    set_regs(8191, 127, 20, 8191);
    random_phase(5, 30);
    set_regs(2, 16, FILL, FILL);
    random_phase(8, 40);

    drain();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
